### rtl/core/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define OWBM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define OWBM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Types and constants of the 1-Wire bus master: phase encoding, request kinds,
// register indexes and register reset values.
// ----------------------------------------------------------------------------
package owbm_pkg;

	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned REG_W    = 10;

	typedef logic [REG_W-1:0] ticks_t;
	typedef logic [2:0]       reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_RST_LOW = 3'd1,
		PH_PWAIT   = 3'd2,
		PH_WR_LOW  = 3'd3,
		PH_WR_DATA = 3'd4,
		PH_RD_LOW  = 3'd5,
		PH_RD_SAMP = 3'd6,
		PH_TAIL    = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_RESET = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	localparam reg_idx_t REG_RESET_LOW   = 3'd0;
	localparam reg_idx_t REG_PRES_WAIT   = 3'd1;
	localparam reg_idx_t REG_PRES_TAIL   = 3'd2;
	localparam reg_idx_t REG_WRITE_LOW   = 3'd3;
	localparam reg_idx_t REG_WRITE_DATA  = 3'd4;
	localparam reg_idx_t REG_READ_LOW    = 3'd5;
	localparam reg_idx_t REG_READ_SAMPLE = 3'd6;
	localparam reg_idx_t REG_READ_TAIL   = 3'd7;

	// Marks a tail phase that belongs to a reset sequence rather than a read slot.
	localparam logic [3:0] RESET_MARK = 4'd15;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	localparam ticks_t REG_RESET_VALS [NUM_REGS] = '{
		10'd600, 10'd80, 10'd600, 10'd15, 10'd80, 10'd1, 10'd10, 10'd45
	};

endpackage

### rtl/core/onewire_bus_master.sv
// ----------------------------------------------------------------------------
// onewire_bus_master
// 1-Wire bus master: reset/presence, byte write and byte read sequences,
// timed by tick requests that carry the sampled bus level.
// ----------------------------------------------------------------------------
//   channel   direction   handshake            payload
//   in        input       in_valid/in_stall    kind, data_byte, bus_level
//   out       output      out_valid/out_stall  drive_low, busy_res, done_res,
//                                              presence, read_byte
//   cfg       input       cfg_wr_en            cfg_index, cfg_data
//
// One request is taken per cycle while in_stall is low; each gives one result
// through the input register, then the result register. The phase machine
// updates once per request.
// arst_n clears the phase machine and both valid flags and loads the register reset values.
// A stalled result holds; the input register keeps taking requests until both
// stages are full.
module onewire_bus_master (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              kind,
	input  logic [7:0]              data_byte,
	input  logic                    bus_level,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    drive_low,
	output logic                    busy_res,
	output logic                    done_res,
	output logic                    presence,
	output logic [7:0]              read_byte,
	input  logic                    cfg_wr_en,
	input  owbm_pkg::reg_idx_t      cfg_index,
	input  owbm_pkg::ticks_t        cfg_data
);
	import owbm_pkg::*;

	ticks_t     regs_q [NUM_REGS];

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] data_s1;
	logic       level_s1;

	logic       valid_s2;
	logic       drive_s2;
	logic       busy_s2;
	logic       done_s2;
	logic       pres_s2;
	logic [7:0] rbyte_s2;

	phase_t     phase_q, phase_d;
	ticks_t     timer_q, timer_d;
	logic [3:0] bits_q, bits_d;
	logic [7:0] shift_q, shift_d;
	logic       pres_q, pres_d;
	logic       line_q, line_d;
	logic [7:0] rres_q, rres_d;
	logic       done_d;

	logic       advance;
	logic       step;
	ticks_t     timer_inc;
	ticks_t     lim;
	logic [3:0] bits_inc;
	logic [7:0] shift_rd;

	assign advance  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= REG_RESET_VALS[i];
			end
		end else if (cfg_wr_en) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1  <= kind;
			data_s1  <= data_byte;
			level_s1 <= bus_level;
		end
	end

	assign timer_inc = timer_q + 10'd1;
	assign bits_inc  = bits_q + 4'd1;
	assign shift_rd  = {level_s1, shift_q[7:1]};

	always_comb begin
		unique case (phase_q)
			PH_RST_LOW: lim = regs_q[REG_RESET_LOW];
			PH_PWAIT:   lim = regs_q[REG_PRES_WAIT];
			PH_WR_LOW:  lim = regs_q[REG_WRITE_LOW];
			PH_WR_DATA: lim = regs_q[REG_WRITE_DATA];
			PH_RD_LOW:  lim = regs_q[REG_READ_LOW];
			PH_RD_SAMP: lim = regs_q[REG_READ_SAMPLE];
			default:    lim = (bits_q == RESET_MARK) ? regs_q[REG_PRES_TAIL]
			                                         : regs_q[REG_READ_TAIL];
		endcase
	end

	// Next state of the phase machine for the request in the input register.
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		pres_d  = pres_q;
		line_d  = line_q;
		rres_d  = rres_q;
		done_d  = 1'b0;
		if (phase_q == PH_IDLE) begin
			unique case (kind_t'(kind_s1))
				KIND_RESET: begin
					pres_d  = 1'b0;
					bits_d  = 4'd0;
					phase_d = PH_RST_LOW;
					timer_d = '0;
					line_d  = 1'b1;
				end
				KIND_WRITE: begin
					shift_d = data_s1;
					bits_d  = 4'd0;
					phase_d = PH_WR_LOW;
					timer_d = '0;
					line_d  = 1'b1;
				end
				KIND_READ: begin
					shift_d = 8'd0;
					bits_d  = 4'd0;
					phase_d = PH_RD_LOW;
					timer_d = '0;
					line_d  = 1'b1;
				end
				default: ;
			endcase
		end else if (kind_t'(kind_s1) == KIND_TICK) begin
			timer_d = timer_inc;
			if (timer_inc >= lim) begin
				timer_d = '0;
				unique case (phase_q)
					PH_RST_LOW: begin
						phase_d = PH_PWAIT;
						line_d  = 1'b0;
					end
					PH_PWAIT: begin
						pres_d = !level_s1;
						bits_d = RESET_MARK;
						line_d = 1'b0;
						// A zero tail ends the sequence on the sampling tick.
						if (regs_q[REG_PRES_TAIL] == '0) begin
							phase_d = PH_IDLE;
							done_d  = 1'b1;
						end else begin
							phase_d = PH_TAIL;
						end
					end
					PH_WR_LOW: begin
						phase_d = PH_WR_DATA;
						line_d  = !shift_q[0];
					end
					PH_WR_DATA: begin
						shift_d = {1'b0, shift_q[7:1]};
						bits_d  = bits_inc;
						if (bits_inc >= BITS_PER_BYTE) begin
							phase_d = PH_IDLE;
							line_d  = 1'b0;
							done_d  = 1'b1;
						end else begin
							phase_d = PH_WR_LOW;
							line_d  = 1'b1;
						end
					end
					PH_RD_LOW: begin
						phase_d = PH_RD_SAMP;
						line_d  = 1'b0;
					end
					PH_RD_SAMP: begin
						shift_d = shift_rd;
						bits_d  = bits_inc;
						line_d  = 1'b0;
						phase_d = PH_TAIL;
						if (regs_q[REG_READ_TAIL] == '0) begin
							if (bits_inc >= BITS_PER_BYTE) begin
								rres_d  = shift_rd;
								phase_d = PH_IDLE;
								done_d  = 1'b1;
							end else begin
								phase_d = PH_RD_LOW;
								line_d  = 1'b1;
							end
						end
					end
					default: begin
						if (bits_q == RESET_MARK) begin
							phase_d = PH_IDLE;
							line_d  = 1'b0;
							done_d  = 1'b1;
						end else if (bits_q >= BITS_PER_BYTE) begin
							rres_d  = shift_q;
							phase_d = PH_IDLE;
							line_d  = 1'b0;
							done_d  = 1'b1;
						end else begin
							phase_d = PH_RD_LOW;
							line_d  = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			bits_q  <= 4'd0;
			shift_q <= 8'd0;
			pres_q  <= 1'b0;
			line_q  <= 1'b0;
			rres_q  <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
			line_q  <= line_d;
			rres_q  <= rres_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			drive_s2 <= line_d;
			busy_s2  <= (phase_d != PH_IDLE);
			done_s2  <= done_d;
			pres_s2  <= pres_d;
			rbyte_s2 <= rres_d;
		end
	end

	always_comb begin
		out_valid = valid_s2;
		drive_low = drive_s2;
		busy_res  = busy_s2;
		done_res  = done_s2;
		presence  = pres_s2;
		read_byte = rbyte_s2;
	end

endmodule

### rtl/core/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks of the 1-Wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module owbm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       drive_low,
	input logic       busy_res,
	input logic       done_res,
	input logic       presence,
	input logic [7:0] read_byte
);

	// An operation that completes leaves the master idle.
	`OWBM_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res)

	// An idle master never holds the bus low.
	`OWBM_ASSERT_NOW(a_idle_released, out_valid && !busy_res, !drive_low)

	// A stalled result holds until taken.
	`OWBM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(drive_low) && $stable(busy_res) && $stable(done_res)
		&& $stable(presence) && $stable(read_byte))

endmodule

bind onewire_bus_master owbm_checker u_owbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.drive_low (drive_low),
	.busy_res  (busy_res),
	.done_res  (done_res),
	.presence  (presence),
	.read_byte (read_byte)
);

### dv/tb_onewire_bus_master.sv
// ----------------------------------------------------------------------------
// tb_onewire_bus_master
// Self-checking testbench for the 1-Wire bus master. A queue of requests
// (ticks and reset/write/read commands) is replayed into the block under
// random idling on both sides. Every accepted request is run through a local
// predictor of the phase machine, and each result is checked field by field.
// The register set is changed between phases, from the reset values through
// the smallest timings and random short settings up to the largest values.
// ----------------------------------------------------------------------------
module tb_onewire_bus_master;
	timeunit 1ns;
	timeprecision 1ps;

	import owbm_pkg::*;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       level;
	} bus_req_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       done;
		logic       presence;
		logic [7:0] rbyte;
	} bus_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] kind = KIND_TICK;
	logic [7:0] data_byte = 8'h00;
	logic       bus_level = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       presence;
	logic [7:0] read_byte;
	logic       cfg_wr_en = 1'b0;
	reg_idx_t   cfg_index = REG_RESET_LOW;
	ticks_t     cfg_data = '0;

	onewire_bus_master uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.data_byte (data_byte),
		.bus_level (bus_level),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive_low (drive_low),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.presence  (presence),
		.read_byte (read_byte),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	bus_req_t    req_queue[$];
	bus_result_t awaited_results[$];

	bit          idle_en = 1'b1;
	int unsigned n_errors = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked = 0;
	int unsigned n_generated = 0;
	int unsigned n_settings = 0;
	int unsigned n_resets = 0;
	int unsigned n_writes = 0;
	int unsigned n_reads = 0;
	int unsigned n_present = 0;

	// Predicted state of the bus master.
	ticks_t     timing[NUM_REGS];
	phase_t     m_phase;
	ticks_t     m_timer;
	logic [3:0] m_bits;
	logic [7:0] m_shift;
	logic       m_pres;
	logic       m_line;
	logic [7:0] m_rdbyte;

	function automatic void enter_phase(phase_t p, logic drv);
		m_phase = p;
		m_timer = '0;
		m_line  = drv;
	endfunction

	function automatic logic finish_tail();
		if (m_bits == RESET_MARK) begin
			enter_phase(PH_IDLE, 1'b0);
			n_resets++;
			return 1'b1;
		end
		if (m_bits >= BITS_PER_BYTE) begin
			m_rdbyte = m_shift;
			enter_phase(PH_IDLE, 1'b0);
			n_reads++;
			return 1'b1;
		end
		enter_phase(PH_RD_LOW, 1'b1);
		return 1'b0;
	endfunction

	function automatic logic start_tail();
		ticks_t lim;
		lim = (m_bits == RESET_MARK) ? timing[REG_PRES_TAIL] : timing[REG_READ_TAIL];
		enter_phase(PH_TAIL, 1'b0);
		if (lim == '0)
			return finish_tail();
		return 1'b0;
	endfunction

	function automatic bus_result_t predict_bus_step(bus_req_t r);
		ticks_t      lim;
		logic        done;
		bus_result_t res;
		done = 1'b0;
		if (m_phase == PH_IDLE) begin
			case (r.kind)
				KIND_RESET: begin
					m_pres = 1'b0;
					m_bits = '0;
					enter_phase(PH_RST_LOW, 1'b1);
				end
				KIND_WRITE: begin
					m_shift = r.data;
					m_bits  = '0;
					enter_phase(PH_WR_LOW, 1'b1);
				end
				KIND_READ: begin
					m_shift = '0;
					m_bits  = '0;
					enter_phase(PH_RD_LOW, 1'b1);
				end
				default: ;
			endcase
		end else if (r.kind == KIND_TICK) begin
			m_timer = m_timer + 10'd1;
			case (m_phase)
				PH_RST_LOW: lim = timing[REG_RESET_LOW];
				PH_PWAIT:   lim = timing[REG_PRES_WAIT];
				PH_WR_LOW:  lim = timing[REG_WRITE_LOW];
				PH_WR_DATA: lim = timing[REG_WRITE_DATA];
				PH_RD_LOW:  lim = timing[REG_READ_LOW];
				PH_RD_SAMP: lim = timing[REG_READ_SAMPLE];
				default: begin
					lim = (m_bits == RESET_MARK) ? timing[REG_PRES_TAIL]
					                             : timing[REG_READ_TAIL];
				end
			endcase
			if (m_timer >= lim) begin
				case (m_phase)
					PH_RST_LOW: enter_phase(PH_PWAIT, 1'b0);
					PH_PWAIT: begin
						m_pres = ~r.level;
						if (!r.level)
							n_present++;
						m_bits = RESET_MARK;
						done = start_tail();
					end
					PH_WR_LOW: enter_phase(PH_WR_DATA, ~m_shift[0]);
					PH_WR_DATA: begin
						m_shift = m_shift >> 1;
						m_bits  = m_bits + 4'd1;
						if (m_bits >= BITS_PER_BYTE) begin
							enter_phase(PH_IDLE, 1'b0);
							n_writes++;
							done = 1'b1;
						end else begin
							enter_phase(PH_WR_LOW, 1'b1);
						end
					end
					PH_RD_LOW: enter_phase(PH_RD_SAMP, 1'b0);
					PH_RD_SAMP: begin
						m_shift = {r.level, m_shift[7:1]};
						m_bits  = m_bits + 4'd1;
						done = start_tail();
					end
					default: done = finish_tail();
				endcase
			end
		end
		res.drive_low = m_line;
		res.busy      = (m_phase != PH_IDLE);
		res.done      = done;
		res.presence  = m_pres;
		res.rbyte     = m_rdbyte;
		return res;
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			n_errors++;
		end
	endfunction

	// Driver: offers the next queued request once the current one is taken.
	always @(posedge clk) begin : driver
		bus_req_t    nxt;
		bus_req_t    taken;
		int unsigned gap_left;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				taken.kind  = kind_t'(kind);
				taken.data  = data_byte;
				taken.level = bus_level;
				awaited_results.push_back(predict_bus_step(taken));
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (idle_en && req_queue.size() != 0 && $urandom_range(0, 9) == 0) begin
					gap_left = $urandom_range(0, 4);
					in_valid <= 1'b0;
				end else if (req_queue.size() != 0) begin
					nxt = req_queue.pop_front();
					kind      <= nxt.kind;
					data_byte <= nxt.data;
					bus_level <= nxt.level;
					in_valid  <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks results and stalls the output side.
	always @(posedge clk) begin : monitor
		bus_result_t exp_r;
		int unsigned stall_left;
		int unsigned hold_left;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result with no request waiting for it");
					n_errors++;
				end else begin
					exp_r = awaited_results.pop_front();
					check_field("drive_low", exp_r.drive_low, drive_low);
					check_field("busy_res", exp_r.busy, busy_res);
					check_field("done_res", exp_r.done, done_res);
					check_field("presence", exp_r.presence, presence);
					check_field("read_byte", exp_r.rbyte, read_byte);
				end
				n_checked++;
				// Long hold-off so that both pipeline stages fill and the input stalls.
				if (n_checked == 400 || n_checked == 1000)
					hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic int unsigned at_least_one(ticks_t v);
		return (v == '0) ? 1 : int'(v);
	endfunction

	// Ticks a command needs to run to completion under the current timing.
	function automatic int unsigned op_ticks(kind_t k);
		case (k)
			KIND_RESET: return at_least_one(timing[REG_RESET_LOW])
			                   + at_least_one(timing[REG_PRES_WAIT])
			                   + int'(timing[REG_PRES_TAIL]);
			KIND_WRITE: return 8 * (at_least_one(timing[REG_WRITE_LOW])
			                   + at_least_one(timing[REG_WRITE_DATA]));
			KIND_READ:  return 8 * (at_least_one(timing[REG_READ_LOW])
			                   + at_least_one(timing[REG_READ_SAMPLE])
			                   + int'(timing[REG_READ_TAIL]));
			default:    return 0;
		endcase
	endfunction

	function automatic void push_req(kind_t k, logic [7:0] d, logic lvl);
		bus_req_t r;
		r.kind  = k;
		r.data  = d;
		r.level = lvl;
		req_queue.push_back(r);
		n_generated++;
	endfunction

	// Level mode: 0 random, 1 bus held low, 2 bus high. With noisy set, stray
	// commands land between ticks while the block is busy and must be ignored.
	function automatic void push_ticks(int unsigned n, int unsigned mode, bit noisy);
		logic lvl;
		for (int unsigned i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 29) == 0)
				push_req(kind_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
			lvl = (mode == 0) ? 1'($urandom) : (mode == 2);
			push_req(KIND_TICK, 8'($urandom), lvl);
		end
	endfunction

	function automatic void push_op(kind_t k, logic [7:0] d, int unsigned mode, bit noisy);
		push_req(k, d, 1'($urandom));
		push_ticks(op_ticks(k), mode, noisy);
	endfunction

	task automatic wait_drained();
		while (req_queue.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Drains and then ticks the block back to idle before any register write.
	task automatic settle();
		wait_drained();
		while (m_phase != PH_IDLE) begin
			push_ticks(32, 0, 1'b0);
			wait_drained();
		end
	endtask

	task automatic write_timing(input ticks_t vals[NUM_REGS]);
		for (int unsigned i = 0; i < NUM_REGS; i++) begin
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= vals[i];
			timing[i] = vals[i];
		end
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	function automatic ticks_t short_ticks(int unsigned lo);
		if ($urandom_range(0, 9) == 0)
			return ticks_t'($urandom_range(5, 12));
		return ticks_t'($urandom_range(lo, 3));
	endfunction

	task automatic random_traffic(int unsigned n_items);
		int unsigned target;
		int unsigned pick;
		kind_t       k;
		target = n_generated + n_items;
		while (n_generated < target) begin
			pick = $urandom_range(0, 99);
			k = kind_t'($urandom_range(1, 3));
			if (pick < 85) begin
				push_op(k, 8'($urandom), ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0,
				        1'b1);
				push_ticks($urandom_range(0, 2), 0, 1'b0);
			end else if (pick < 93) begin
				// Cut short: the next command may arrive while still busy.
				push_req(k, 8'($urandom), 1'($urandom));
				push_ticks($urandom_range(0, op_ticks(k) - 1), 0, 1'b1);
			end else begin
				repeat ($urandom_range(1, 6))
					push_req(kind_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		#10ms;
		$display("[onewire_bus_master] ERROR");
		$finish;
	end

	initial begin : stimulus
		ticks_t vals[NUM_REGS];
		for (int unsigned i = 0; i < NUM_REGS; i++)
			timing[i] = REG_RESET_VALS[i];
		m_phase  = PH_IDLE;
		m_timer  = '0;
		m_bits   = '0;
		m_shift  = '0;
		m_pres   = 1'b0;
		m_line   = 1'b0;
		m_rdbyte = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: ticks while idle, then a read with commands thrown in
		// while it runs.
		push_req(KIND_TICK, 8'h00, 1'b0);
		push_req(KIND_TICK, 8'hFF, 1'b1);
		push_req(KIND_READ, 8'h00, 1'b0);
		push_req(KIND_WRITE, 8'hFF, 1'b0);
		push_req(KIND_RESET, 8'h00, 1'b1);
		push_req(KIND_READ, 8'h55, 1'b1);
		push_ticks(op_ticks(KIND_READ), 0, 1'b0);
		settle();

		// Shortest timings, both tails zero.
		vals[REG_RESET_LOW]   = 10'd1;
		vals[REG_PRES_WAIT]   = 10'd1;
		vals[REG_PRES_TAIL]   = 10'd0;
		vals[REG_WRITE_LOW]   = 10'd1;
		vals[REG_WRITE_DATA]  = 10'd1;
		vals[REG_READ_LOW]    = 10'd1;
		vals[REG_READ_SAMPLE] = 10'd1;
		vals[REG_READ_TAIL]   = 10'd0;
		write_timing(vals);
		push_op(KIND_RESET, 8'h00, 1, 1'b0);
		push_op(KIND_RESET, 8'h00, 2, 1'b0);
		push_req(KIND_WRITE, 8'h80, 1'b0);
		push_req(KIND_RESET, 8'h00, 1'b1);
		push_ticks(op_ticks(KIND_WRITE), 0, 1'b0);
		push_op(KIND_READ, 8'h00, 2, 1'b0);
		push_req(KIND_TICK, 8'hAA, 1'b1);
		settle();

		for (int unsigned ph = 0; ph < 6; ph++) begin
			vals[REG_RESET_LOW]   = short_ticks(1);
			vals[REG_PRES_WAIT]   = short_ticks(1);
			vals[REG_PRES_TAIL]   = short_ticks(0);
			vals[REG_WRITE_LOW]   = short_ticks(1);
			vals[REG_WRITE_DATA]  = short_ticks(1);
			vals[REG_READ_LOW]    = short_ticks(1);
			vals[REG_READ_SAMPLE] = short_ticks(1);
			vals[REG_READ_TAIL]   = short_ticks(0);
			write_timing(vals);
			random_traffic(120);
			settle();
		end

		// Largest timings: a reset pulse that runs partway with stray commands
		// that must be ignored, no idling on either side.
		idle_en = 1'b0;
		for (int unsigned i = 0; i < NUM_REGS; i++)
			vals[i] = 10'd1023;
		write_timing(vals);
		push_req(KIND_RESET, 8'h00, 1'b0);
		push_ticks(150, 0, 1'b1);
		wait_drained();

		repeat (5) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d expected results never arrived", awaited_results.size());
			n_errors++;
		end
		$display("Checked %0d results for %0d requests over %0d timing settings.",
		         n_checked, n_accepted, n_settings);
		$display("Sequences completed: %0d reset (%0d with presence), %0d write, %0d read.",
		         n_resets, n_present, n_writes, n_reads);
		if (n_errors == 0) begin
			$display("[onewire_bus_master] OK");
		end else begin
			$display("[onewire_bus_master] ERROR");
		end
		$finish;
	end

endmodule
